[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros included by the oscillator RTL.
// Each macro samples on the rising edge of clk and is off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the condition holds, the consequence holds in the same cycle.
`define ASSERT_IMPLIES(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// When the condition holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

[sv/tofr_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle oscillator voice package
// Item modes, sequencer states, multiplier operations and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tofr_pkg;

	// Item modes.
	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_NOTE_ON  = 2'd1,
		MODE_SOFT_OFF = 2'd2,
		MODE_HARD_OFF = 2'd3
	} mode_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	// Operations run on the shared serial multiplier.
	typedef enum logic [2:0] {
		OP_AV,
		OP_AVT,
		OP_G,
		OP_FM,
		OP_STEP,
		OP_REL
	} op_t;

	// Register indexes on the configuration port.
	localparam logic REG_VOLUME   = 1'b0;
	localparam logic REG_FM_DEPTH = 1'b1;

	localparam logic [6:0] VOLUME_RESET = 7'd127;

	// Release gain in Q1.16.
	localparam logic [16:0] GAIN_ONE   = 17'd65536;
	localparam logic [15:0] GAIN_DECAY = 16'd64881;
	localparam logic [16:0] GAIN_FLOOR = 17'd327;
	localparam logic [32:0] GAIN_RND   = 33'd32768;

	// Divisor of the volume scale.
	localparam logic [6:0] DIV_C = 7'd127;

	// Serial multiplier geometry: multiplicand and multiplier widths.
	localparam int MC_W  = 39;
	localparam int MP_W  = 32;
	localparam int CNT_W = 6;

	// Multiplier bits consumed by each operation, and quotient bits of the divider.
	localparam logic [CNT_W-1:0] N_AV   = 6'd7;
	localparam logic [CNT_W-1:0] N_AVT  = 6'd16;
	localparam logic [CNT_W-1:0] N_G    = 6'd17;
	localparam logic [CNT_W-1:0] N_FM   = 6'd16;
	localparam logic [CNT_W-1:0] N_STEP = 6'd32;
	localparam logic [CNT_W-1:0] N_REL  = 6'd16;
	localparam logic [CNT_W-1:0] N_DIV  = 6'd16;

	// FM factor unity in Q29.
	localparam logic [31:0] FM_ONE = 32'h2000_0000;

endpackage

[sv/triangle_oscillator_fm_release.sv]
// ----------------------------------------------------------------------------
// Triangle oscillator voice with FM and exponential release
// One voice: phase accumulator, bipolar triangle shaper, volume, FM, release.
// Input channel (in_valid/in_stall) carries mode, phase_step, note_level and
// fm_sample. Note-on and both note-offs give no result.
// Each tick gives one transfer on the output channel (sample_out, voice_active).
// An active tick runs on the bit-serial shift-add multiplier, which consumes one
// multiplier bit per cycle over five products (six while releasing), and on
// the one-bit-a-step divider.
// The result waits in an output register; the next item is taken while it
// waits, and a new result waits in place until the receiver lowers out_stall.
// Reset clears the voice (silent, phase 0), volume to 127 and FM depth to 0.
// The user must write registers over the APB port only while the voice is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_oscillator_fm_release
	import tofr_pkg::*;
#(
	parameter int OUT_WIDTH   = 24,
	parameter int PHASE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  mode,
	input  logic [31:0]                 phase_step,
	input  logic [15:0]                 note_level,
	input  logic signed [15:0]          fm_sample,
	// Output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_WIDTH-1:0] sample_out,
	output logic                        voice_active,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam logic [OUT_WIDTH:0] MAX_POS =
		(OUT_WIDTH+1)'((64'd1 << (OUT_WIDTH-1)) - 64'd1);
	localparam logic [OUT_WIDTH:0] MAX_NEG = MAX_POS + 1'b1;
	localparam logic [56:0] ROUND_C = 57'(DIV_C) << 30;

	// Configuration and voice state.
	logic [6:0]             volume_q;
	logic [15:0]            depth_q;
	logic [PHASE_WIDTH-1:0] phase_q;
	logic [31:0]            step_q;
	logic [15:0]            amp_q;
	logic [16:0]            rel_q;
	logic                   active_q;

	// Sequencer.
	state_t           state_q, state_d;
	op_t              op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_accept, tick_go, out_free, out_load;
	logic             mul_done, div_done;

	// Serial multiplier.
	logic [MC_W-1:0]      mc_q, hi_q;
	logic [MP_W-1:0]      lo_q;
	logic [MC_W:0]        mul_sum;
	logic [MC_W+MP_W-1:0] prod_all;
	logic                 ld_en;
	op_t                  ld_op;
	logic [MC_W-1:0]      ld_mc;
	logic [MP_W-1:0]      ld_mp;
	logic [CNT_W-1:0]     ld_n;

	// Products of each operation.
	logic [22:0] p_av;
	logic [38:0] p_avt;
	logic [55:0] p_g;
	logic [31:0] p_fm;
	logic [63:0] p_step;
	logic [32:0] p_rel;

	// Per-tick operands.
	logic        tneg_q, fmneg_q, facneg_q;
	logic [15:0] magt_q, fmmag_q;
	logic [16:0] g_eff;

	// Triangle shaper.
	logic [PHASE_WIDTH-1:0] tri_u;
	logic [PHASE_WIDTH:0]   tri_2u;
	logic [16:0]            tri_q, tri_diff;
	logic                   tri_neg;
	logic [15:0]            fm_raw, fm_mag;

	// Rounding and division by 127.
	logic [56:0] rnd_sum;
	logic [25:0] n2;
	logic [6:0]  rem_q, div_rem;
	logic [15:0] dq_q;
	logic [7:0]  div_r2, div_sub;
	logic        div_ge;

	// Sample shaping.
	logic [OUT_WIDTH:0]   q_e, mag_p, mag_n;
	logic [OUT_WIDTH-1:0] samp_d, samp_q;

	// FM factor and phase advance.
	logic                   fac_neg;
	logic [31:0]            fac_mag;
	logic [PHASE_WIDTH-1:0] delta;
	logic [32:0]            rel_sum;
	logic [16:0]            rel_new;

	// Output register.
	logic                 out_valid_q, vact_q;
	logic [OUT_WIDTH-1:0] sample_q;

	// Handshake terms.
	assign in_accept = in_valid && !in_stall;
	assign tick_go   = in_accept && (mode == MODE_TICK) && active_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign mul_done  = (state_q == ST_MUL) && (cnt_q == '0);
	assign div_done  = (state_q == ST_DIV) && (cnt_q == '0);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && (mode == MODE_TICK)) begin
					state_d = active_q ? ST_MUL : ST_FIN;
				end
			end
			ST_MUL: begin
				if (cnt_q == '0) begin
					case (op_q)
						OP_G:    state_d = ST_DIV;
						OP_STEP: state_d = (rel_q != '0) ? ST_MUL : ST_FIN;
						OP_REL:  state_d = ST_FIN;
						default: state_d = ST_MUL;
					endcase
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_MUL;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_FIN) && out_free;
	end

	// Triangle of the current phase, and the modulator magnitude.
	always_comb begin
		tri_u    = phase_q[PHASE_WIDTH-1] ? (PHASE_WIDTH'(0) - phase_q) : phase_q;
		tri_2u   = {tri_u, 1'b0};
		tri_q    = tri_2u[PHASE_WIDTH -: 17];
		tri_neg  = (tri_q[16:15] == 2'b00);
		tri_diff = tri_neg ? (17'd32768 - tri_q) : (tri_q - 17'd32768);
		fm_raw   = fm_sample;
		fm_mag   = fm_raw[15] ? (16'd0 - fm_raw) : fm_raw;
	end

	// One multiplier bit per cycle; products are read at fixed offsets.
	assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);
	assign prod_all = {hi_q, lo_q};
	assign p_av     = prod_all[(MP_W - 7) +: 23];
	assign p_avt    = prod_all[(MP_W - 16) +: 39];
	assign p_g      = prod_all[(MP_W - 17) +: 56];
	assign p_fm     = prod_all[(MP_W - 16) +: 32];
	assign p_step   = prod_all[0 +: 64];
	assign p_rel    = prod_all[(MP_W - 16) +: 33];
	assign g_eff    = (rel_q != '0) ? rel_q : GAIN_ONE;

	// FM factor 1 - fm*depth, as sign and magnitude.
	always_comb begin
		fac_neg = !fmneg_q && (p_fm > FM_ONE);
		if (fmneg_q) begin
			fac_mag = FM_ONE + p_fm;
		end else if (fac_neg) begin
			fac_mag = p_fm - FM_ONE;
		end else begin
			fac_mag = FM_ONE - p_fm;
		end
		delta   = PHASE_WIDTH'(p_step >> 29);
		rel_sum = p_rel + GAIN_RND;
		rel_new = rel_sum[32:16];
	end

	// Rounding offset and one restoring division step by 127.
	always_comb begin
		rnd_sum = 57'(p_g) + ROUND_C;
		n2      = rnd_sum[56:31];
		div_r2  = {rem_q, dq_q[15]};
		div_ge  = (div_r2 >= {1'b0, DIV_C});
		div_sub = div_r2 - {1'b0, DIV_C};
		div_rem = div_ge ? div_sub[6:0] : div_r2[6:0];
	end

	// Sign and saturation of the sample.
	always_comb begin
		q_e    = (OUT_WIDTH+1)'(dq_q);
		mag_p  = (q_e > MAX_POS) ? MAX_POS : q_e;
		mag_n  = (q_e > MAX_NEG) ? MAX_NEG : q_e;
		samp_d = tneg_q ? OUT_WIDTH'((OUT_WIDTH+1)'(0) - mag_n) : OUT_WIDTH'(mag_p);
	end

	// Operand load for the next multiplier operation.
	always_comb begin
		ld_en = 1'b0;
		ld_op = OP_AV;
		ld_mc = '0;
		ld_mp = '0;
		ld_n  = '0;
		case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					ld_en = 1'b1;
					ld_op = OP_AV;
					ld_mc = MC_W'(amp_q);
					ld_mp = MP_W'(volume_q);
					ld_n  = N_AV;
				end
			end
			ST_MUL: begin
				if (cnt_q == '0) begin
					case (op_q)
						OP_AV: begin
							ld_en = 1'b1;
							ld_op = OP_AVT;
							ld_mc = MC_W'(p_av);
							ld_mp = MP_W'(magt_q);
							ld_n  = N_AVT;
						end
						OP_AVT: begin
							ld_en = 1'b1;
							ld_op = OP_G;
							ld_mc = p_avt;
							ld_mp = MP_W'(g_eff);
							ld_n  = N_G;
						end
						OP_FM: begin
							ld_en = 1'b1;
							ld_op = OP_STEP;
							ld_mc = MC_W'(step_q);
							ld_mp = fac_mag;
							ld_n  = N_STEP;
						end
						OP_STEP: begin
							if (rel_q != '0) begin
								ld_en = 1'b1;
								ld_op = OP_REL;
								ld_mc = MC_W'(rel_q);
								ld_mp = MP_W'(GAIN_DECAY);
								ld_n  = N_REL;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					ld_en = 1'b1;
					ld_op = OP_FM;
					ld_mc = MC_W'(depth_q);
					ld_mp = MP_W'(fmmag_q);
					ld_n  = N_FM;
				end
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_AV;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ld_en) begin
				op_q  <= ld_op;
				cnt_q <= ld_n;
			end else if (mul_done && (op_q == OP_G)) begin
				cnt_q <= N_DIV;
			end else if (((state_q == ST_MUL) || (state_q == ST_DIV)) && (cnt_q != '0)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Voice state, configuration registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q    <= VOLUME_RESET;
			depth_q     <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			amp_q       <= '0;
			rel_q       <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Register writes.
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_VOLUME) begin
					volume_q <= pwdata[6:0];
				end else begin
					depth_q <= pwdata[15:0];
				end
			end

			// Note events take effect when accepted.
			if (in_accept) begin
				case (mode)
					MODE_NOTE_ON: begin
						phase_q  <= '0;
						step_q   <= phase_step;
						amp_q    <= note_level;
						rel_q    <= '0;
						active_q <= (phase_step != '0);
					end
					MODE_SOFT_OFF: begin
						if (active_q && (rel_q == '0)) begin
							rel_q <= GAIN_ONE;
						end
					end
					MODE_HARD_OFF: begin
						active_q <= 1'b0;
						rel_q    <= '0;
					end
					default: ;
				endcase
			end

			// Phase advance after the sample.
			if (mul_done && (op_q == OP_STEP)) begin
				phase_q <= facneg_q ? (phase_q - delta) : (phase_q + delta);
			end

			// Release decay; the voice ends at the gain floor.
			if (mul_done && (op_q == OP_REL)) begin
				if (rel_new <= GAIN_FLOOR) begin
					rel_q    <= '0;
					active_q <= 1'b0;
				end else begin
					rel_q <= rel_new;
				end
			end

			// Output transfer.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Serial multiplier.
		if (ld_en) begin
			mc_q <= ld_mc;
			hi_q <= '0;
			lo_q <= ld_mp;
		end else if ((state_q == ST_MUL) && (cnt_q != '0)) begin
			hi_q <= mul_sum[MC_W:1];
			lo_q <= {mul_sum[0], lo_q[MP_W-1:1]};
		end

		// Divider: quotient bits shift in where dividend bits leave.
		if (mul_done && (op_q == OP_G)) begin
			rem_q <= n2[22:16];
			dq_q  <= n2[15:0];
		end else if ((state_q == ST_DIV) && (cnt_q != '0)) begin
			rem_q <= div_rem;
			dq_q  <= {dq_q[14:0], div_ge};
		end

		// Operands captured with the tick.
		if (in_accept && (mode == MODE_TICK)) begin
			tneg_q  <= tri_neg;
			magt_q  <= tri_diff[15:0];
			fmneg_q <= fm_raw[15];
			fmmag_q <= fm_mag;
		end

		if (in_accept && (mode == MODE_TICK) && !active_q) begin
			samp_q <= '0;
		end else if (div_done) begin
			samp_q <= samp_d;
		end

		if (mul_done && (op_q == OP_FM)) begin
			facneg_q <= fac_neg;
		end

		if (out_load) begin
			sample_q <= samp_q;
			vact_q   <= active_q;
		end
	end

	// Ports.
	assign out_valid    = out_valid_q;
	assign sample_out   = sample_q;
	assign voice_active = vact_q;
	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == REG_VOLUME) ? {25'd0, volume_q} : {16'd0, depth_q};

	// Checks.
	`ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && (mode == MODE_TICK), in_stall, "tick accepted without going busy")
	`ASSERT_IMPLIES(a_div_rem, state_q == ST_DIV, rem_q < DIV_C, "divider remainder out of range")
	`ASSERT_IMPLIES(a_idle_gain, !active_q, rel_q == '0, "release gain set on a silent voice")
	`ASSERT_ALWAYS(a_gain_max, rel_q <= GAIN_ONE, "release gain above unity")

endmodule
